### rtl/drkr_pkg.sv
// shared types and constants for the dual-role key resolver
package drkr_pkg;

    // dual-role window size, capped at the four entry registers
    localparam int KEY_SLOTS  = 4;
    localparam int SLOT_COUNT = (KEY_SLOTS < 4) ? KEY_SLOTS : 4;
    localparam int MAX_BEATS  = 3;

    // config register indexes
    localparam logic [2:0] REG_WINDOW_BASE = 3'd0;
    localparam logic [2:0] REG_ENTRY_ZERO  = 3'd1;
    localparam logic [2:0] REG_ENTRY_ONE   = 3'd2;
    localparam logic [2:0] REG_ENTRY_TWO   = 3'd3;
    localparam logic [2:0] REG_ENTRY_THREE = 3'd4;

    // action codes
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_REG   = 2'd1;
    localparam logic [1:0] ACT_UNREG = 2'd2;
    localparam logic [1:0] ACT_TAP   = 2'd3;

    // resolver tracking state
    typedef struct packed {
        logic        holding_valid;
        logic [1:0]  holding_index;
        logic        interrupted;
        logic [15:0] overlap_code;
    } drkr_state_t;

    // result beats produced by one event
    typedef struct packed {
        logic [MAX_BEATS-1:0][1:0]  act;
        logic [MAX_BEATS-1:0][15:0] code;
        logic [1:0]                 count;
        logic                       handled;
        logic                       active;
    } drkr_burst_t;

    // modifier and tap halves of an entry
    function automatic logic [15:0] mod_of(input logic [31:0] entry);
        mod_of = entry[31:16];
    endfunction

    function automatic logic [15:0] tap_of(input logic [31:0] entry);
        tap_of = entry[15:0];
    endfunction

endpackage

### rtl/drkr_resolve.sv
// combinational event resolution: result beats and next tracking state
module drkr_resolve (
    input  logic [15:0]                key_code,
    input  logic                       pressed,
    input  logic                       handled_in,
    input  logic [15:0]                window_base,
    input  logic [3:0][31:0]           entries,
    input  drkr_pkg::drkr_state_t      state_cur,
    output drkr_pkg::drkr_state_t      state_next,
    output drkr_pkg::drkr_burst_t      burst
);
    import drkr_pkg::*;

    logic [15:0] diff;
    logic        in_window;
    logic [1:0]  idx;
    logic [31:0] held_entry;
    logic [31:0] key_entry;

    // window hit and slot index
    assign diff      = key_code - window_base;
    assign in_window = (key_code >= window_base) && (diff < 16'(SLOT_COUNT));
    assign idx       = diff[1:0];
    assign held_entry = entries[state_cur.holding_index];
    assign key_entry  = entries[idx];

    // event decision, beats appended in order
    always_comb begin
        logic [1:0] n;
        n          = 2'd0;
        state_next = state_cur;
        burst      = '0;
        burst.handled = handled_in;
        if (!in_window) begin
            if (state_cur.holding_valid && !state_cur.interrupted && pressed) begin
                state_next.interrupted = 1'b1;
                burst.act[n]  = ACT_REG;
                burst.code[n] = mod_of(held_entry);
                n = n + 2'd1;
            end
        end else if (!handled_in) begin
            if (state_cur.holding_valid) begin
                if (idx == state_cur.holding_index) begin
                    if (!pressed) begin
                        if (state_cur.interrupted) begin
                            burst.act[n]  = ACT_UNREG;
                            burst.code[n] = mod_of(held_entry);
                        end else begin
                            burst.act[n]  = ACT_TAP;
                            burst.code[n] = tap_of(held_entry);
                        end
                        n = n + 2'd1;
                        if (state_cur.overlap_code != 16'd0) begin
                            burst.act[n]  = ACT_UNREG;
                            burst.code[n] = state_cur.overlap_code;
                            n = n + 2'd1;
                        end
                        state_next.holding_valid = 1'b0;
                    end
                end else if (pressed) begin
                    if (!state_cur.interrupted) begin
                        state_next.interrupted = 1'b1;
                        burst.act[n]  = ACT_REG;
                        burst.code[n] = mod_of(held_entry);
                        n = n + 2'd1;
                    end
                    if (state_cur.overlap_code != 16'd0) begin
                        burst.act[n]  = ACT_UNREG;
                        burst.code[n] = state_cur.overlap_code;
                        n = n + 2'd1;
                    end
                    state_next.overlap_code = tap_of(key_entry);
                    burst.act[n]  = ACT_REG;
                    burst.code[n] = tap_of(key_entry);
                    n = n + 2'd1;
                end else begin
                    // overlap release compares and sends the tap code
                    if (tap_of(key_entry) == state_cur.overlap_code) begin
                        state_next.overlap_code = 16'd0;
                    end
                    burst.act[n]  = ACT_UNREG;
                    burst.code[n] = tap_of(key_entry);
                    n = n + 2'd1;
                end
            end else if (pressed) begin
                state_next.holding_valid = 1'b1;
                state_next.holding_index = idx;
                state_next.interrupted   = 1'b0;
                state_next.overlap_code  = 16'd0;
            end
            burst.handled = 1'b1;
        end
        // no action still yields one beat
        if (n == 2'd0) begin
            burst.act[0]  = ACT_NONE;
            burst.code[0] = 16'd0;
            n = 2'd1;
        end
        burst.count  = n;
        burst.active = state_next.holding_valid;
    end

endmodule

### rtl/dual_role_key_resolver.sv
// dual-role key resolver top level: event register, resolver, result beat buffer
//
//  channel  dir  beat contents (low bit first)
//  s_axis   in   key_code[15:0], pressed[16], handled_in[17], zero pad to 24
//  m_axis   out  action[1:0], code[17:2], handled_out[18], dual_active[19], pad to 24;
//                tlast marks the final beat of an event
//  cfg      in   write enable, register index, 32-bit data
//
// one event is resolved combinationally from the event register into the
// result buffer, then drains one to three beats, one per cycle while m_tready is high.
// a new event is taken every cycle while the buffer is empty or its last beat is taken,
// so a steady stream loads each new event as the last beat of the one before is taken.
// aresetn is synchronous and clears tracking state, config and both buffers.
// stalls on m_tready hold the buffer and back up into the event register.
module dual_role_key_resolver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key_code, pressed, handled_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // action, code, handled_out, dual_active
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import drkr_pkg::*;

    logic [15:0]      base_reg;
    logic [3:0][31:0] entry_reg;
    drkr_state_t      state_reg, state_next;
    drkr_burst_t      burst_next, burst_reg;
    logic             in_valid_reg;
    logic [17:0]      in_data_reg;
    logic             buf_free;
    logic             in_move;
    logic             m_take;

    // handshake control
    assign m_take   = m_tvalid && m_tready;
    assign buf_free = (burst_reg.count == 2'd0) || ((burst_reg.count == 2'd1) && m_tready);
    assign in_move  = in_valid_reg && buf_free;
    assign s_tready = aresetn && (!in_valid_reg || in_move);

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            entry_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WINDOW_BASE: base_reg     <= cfg_wdata[15:0];
                REG_ENTRY_ZERO:  entry_reg[0] <= cfg_wdata;
                REG_ENTRY_ONE:   entry_reg[1] <= cfg_wdata;
                REG_ENTRY_TWO:   entry_reg[2] <= cfg_wdata;
                REG_ENTRY_THREE: entry_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // event input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[17:0];
        end
    end

    drkr_resolve u_resolve (
        .key_code    (in_data_reg[15:0]),
        .pressed     (in_data_reg[16]),
        .handled_in  (in_data_reg[17]),
        .window_base (base_reg),
        .entries     (entry_reg),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .burst       (burst_next)
    );

    // tracking state advances when an event is resolved
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_move) begin
            state_reg <= state_next;
        end
    end

    // result beat buffer, shifts down as beats are taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_reg <= '0;
        end else if (in_move) begin
            burst_reg <= burst_next;
        end else if (m_take) begin
            burst_reg.act[0]  <= burst_reg.act[1];
            burst_reg.act[1]  <= burst_reg.act[2];
            burst_reg.code[0] <= burst_reg.code[1];
            burst_reg.code[1] <= burst_reg.code[2];
            burst_reg.count   <= burst_reg.count - 2'd1;
        end
    end

    // output beat
    assign m_tvalid = (burst_reg.count != 2'd0);
    assign m_tlast  = (burst_reg.count == 2'd1);
    assign m_tdata  = {4'd0, burst_reg.active, burst_reg.handled,
                       burst_reg.code[0], burst_reg.act[0]};

    // a resolved event always leaves at least one beat
    a_load_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_move |=> m_tvalid)
        else $error("resolved event left no result beat");

    // no new event is loaded while more than one beat remains
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !in_move)
        else $error("event loaded over pending beats");

    // beat count holds while the output stalls
    a_count_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (burst_reg.count == $past(burst_reg.count)))
        else $error("beat count changed during stall");

endmodule

### dv/tb_top.sv
// testbench for the dual-role key resolver: directed and random key events, scoreboarded beats
`timescale 1ns / 100ps

module tb_top;
    import drkr_pkg::*;

    // one key event as it travels on the input stream
    typedef struct packed {
        logic [15:0] key;
        logic        pressed;
        logic        handled;
    } key_event_t;

    // one result beat as it leaves the block
    typedef struct packed {
        logic [1:0]  act;
        logic [15:0] code;
        logic        handled;
        logic        active;
        logic        last;
    } action_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // key_code, pressed, handled_in
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // action, code, handled_out, dual_active
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    // shadow of the configuration and of the resolver state
    logic [15:0] window_base;
    logic [31:0] entry_regs [4];
    logic        hold_valid;
    logic [1:0]  hold_slot;
    logic        hold_interrupted;
    logic [15:0] overlap_tap;

    action_beat_t expected_beats[$];
    bit          sender_idles;
    bit          sink_idles;
    int          events_sent;
    int          beats_checked;
    int          mismatches;

    dual_role_key_resolver uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

    // result side backpressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = !sink_idles || ($urandom_range(0, 99) >= 32);
        end
    end

    function automatic logic [15:0] mod_code(input logic [1:0] slot);
        return entry_regs[slot][31:16];
    endfunction

    function automatic logic [15:0] tap_code(input logic [1:0] slot);
        return entry_regs[slot][15:0];
    endfunction

    // work out the beats of one accepted event and queue them
    task automatic resolve_event(input key_event_t ev);
        action_beat_t beats[$];
        action_beat_t b;
        logic [16:0]  window_end;
        logic [1:0]   slot;
        logic [15:0]  tap;
        logic         handled;
        handled = ev.handled;
        window_end = {1'b0, window_base} + 17'(SLOT_COUNT);
        b = '0;
        if (!(ev.key >= window_base && {1'b0, ev.key} < window_end)) begin
            // ordinary key: first press interrupts a held dual-role key
            if (hold_valid && !hold_interrupted && ev.pressed) begin
                hold_interrupted = 1'b1;
                b.act = ACT_REG; b.code = mod_code(hold_slot); beats.push_back(b);
            end
        end else if (!handled) begin
            slot = 2'(ev.key - window_base);
            if (hold_valid) begin
                if (slot == hold_slot) begin
                    if (!ev.pressed) begin
                        if (hold_interrupted) begin
                            b.act = ACT_UNREG; b.code = mod_code(hold_slot);
                        end else begin
                            b.act = ACT_TAP; b.code = tap_code(hold_slot);
                        end
                        beats.push_back(b);
                        if (overlap_tap != 16'd0) begin
                            b.act = ACT_UNREG; b.code = overlap_tap; beats.push_back(b);
                        end
                        hold_valid = 1'b0;
                    end
                end else begin
                    // another dual-role key acts as its plain tap code
                    tap = tap_code(slot);
                    if (ev.pressed) begin
                        if (!hold_interrupted) begin
                            hold_interrupted = 1'b1;
                            b.act = ACT_REG; b.code = mod_code(hold_slot); beats.push_back(b);
                        end
                        if (overlap_tap != 16'd0) begin
                            b.act = ACT_UNREG; b.code = overlap_tap; beats.push_back(b);
                        end
                        overlap_tap = tap;
                        b.act = ACT_REG; b.code = tap; beats.push_back(b);
                    end else begin
                        if (tap == overlap_tap) overlap_tap = 16'd0;
                        b.act = ACT_UNREG; b.code = tap; beats.push_back(b);
                    end
                end
            end else if (ev.pressed) begin
                hold_valid = 1'b1;
                hold_slot = slot;
                hold_interrupted = 1'b0;
                overlap_tap = 16'd0;
            end
            handled = 1'b1;
        end
        if (beats.size() == 0) begin
            b.act = ACT_NONE; b.code = 16'd0; beats.push_back(b);
        end
        foreach (beats[i]) begin
            beats[i].handled = handled;
            beats[i].active = hold_valid;
            beats[i].last = (i == beats.size() - 1);
            expected_beats.push_back(beats[i]);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        action_beat_t got;
        action_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[1:0], m_tdata[17:2], m_tdata[18], m_tdata[19], m_tlast};
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat act=%0d code=%h handled=%b active=%b last=%b",
                             got.act, got.code, got.handled, got.active, got.last);
            end else begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (got.act != want.act || got.code != want.code ||
                    got.handled != want.handled || got.active != want.active ||
                    got.last != want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("beat %0d: expected act=%0d code=%h handled=%b active=%b last=%b",
                                 beats_checked, want.act, want.code, want.handled,
                                 want.active, want.last);
                        $display("    got act=%0d code=%h handled=%b active=%b last=%b",
                                 got.act, got.code, got.handled, got.active, got.last);
                    end
                end
            end
        end
    end

    // send one event; starts and ends on a falling edge
    task automatic send_event(input logic [15:0] key, input logic pressed, input logic handled);
        key_event_t ev;
        ev = '{key: key, pressed: pressed, handled: handled};
        while (sender_idles && $urandom_range(0, 99) < 32) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {6'd0, handled, pressed, key};
        do @(posedge aclk); while (!s_tready);
        resolve_event(ev);
        events_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // hold off until every expected beat has come and the block is quiet
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (addr == REG_WINDOW_BASE) window_base = data[15:0];
        else entry_regs[2'(addr - REG_ENTRY_ZERO)] = data;
    endtask

    task automatic program_window(input logic [15:0] base, input logic [31:0] e0,
                                  input logic [31:0] e1, input logic [31:0] e2,
                                  input logic [31:0] e3);
        wait_drained();
        write_reg(REG_WINDOW_BASE, {16'd0, base});
        write_reg(REG_ENTRY_ZERO, e0);
        write_reg(REG_ENTRY_ONE, e1);
        write_reg(REG_ENTRY_TWO, e2);
        write_reg(REG_ENTRY_THREE, e3);
    endtask

    // highest slot that does not run past the top of the code space
    function automatic int top_slot();
        return (32'(window_base) + SLOT_COUNT - 1 > 65535) ? 65535 - window_base
                                                          : SLOT_COUNT - 1;
    endfunction

    function automatic logic [15:0] dual_key();
        return window_base + 16'($urandom_range(0, top_slot()));
    endfunction

    function automatic logic [15:0] plain_key();
        logic [15:0] k;
        do k = 16'($urandom); while (k >= window_base && 32'(k) <= 32'(window_base) + top_slot());
        return k;
    endfunction

    // reset values of config and state
    task automatic test_reset_defaults();
        send_event(16'h0001, 1'b1, 1'b0);
        send_event(16'h1234, 1'b1, 1'b0);
        send_event(16'h0001, 1'b0, 1'b0);
    endtask

    // tap, interrupt, overlap and the pass-through cases
    task automatic test_directed_cases();
        program_window(16'h0100, {16'hE001, 16'h0004}, {16'hE002, 16'h0005},
                       {16'hE003, 16'h0000}, {16'hE004, 16'h0005});
        send_event(16'h0100, 1'b1, 1'b0);
        send_event(16'h0100, 1'b0, 1'b0);   // plain tap
        send_event(16'h0100, 1'b1, 1'b0);
        send_event(16'h0020, 1'b1, 1'b0);   // interrupted by ordinary key
        send_event(16'h0020, 1'b0, 1'b1);   // ordinary release, already handled
        send_event(16'h0100, 1'b1, 1'b0);   // same key again while held
        send_event(16'h0101, 1'b1, 1'b0);   // other dual key becomes overlap
        send_event(16'h0103, 1'b1, 1'b0);   // replaces overlap with same tap
        send_event(16'h0101, 1'b0, 1'b0);   // tap matches overlap, cleared
        send_event(16'h0100, 1'b0, 1'b0);
        send_event(16'h0100, 1'b1, 1'b0);
        send_event(16'h0102, 1'b1, 1'b0);   // overlap with tap code zero
        send_event(16'h0100, 1'b0, 1'b0);
        send_event(16'h0100, 1'b1, 1'b0);
        send_event(16'h0101, 1'b1, 1'b0);
        send_event(16'h0100, 1'b0, 1'b0);   // release with overlap pending
        send_event(16'h0101, 1'b1, 1'b1);   // dual key already handled
        send_event(16'h0102, 1'b0, 1'b0);   // dual release with none held
        send_event(16'hFFFF, 1'b1, 1'b1);
        send_event(16'h0000, 1'b0, 1'b0);
    endtask

    // window at the top of the code space, extreme entries
    task automatic test_window_edges();
        program_window(16'hFFFC, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_FFFF);
        send_event(16'hFFFF, 1'b1, 1'b0);
        send_event(16'hFFFB, 1'b1, 1'b0);
        send_event(16'hFFFC, 1'b1, 1'b0);
        send_event(16'hFFFF, 1'b0, 1'b0);
        program_window(16'hFFFF, 32'h8000_7FFF, 32'h1111_2222, 32'h3333_4444, 32'h5555_6666);
        send_event(16'hFFFF, 1'b1, 1'b0);
        send_event(16'h0000, 1'b1, 1'b0);   // no wrap past the top code
        send_event(16'hFFFF, 1'b0, 1'b0);
    endtask

    // sender holds off mid-stream until the block has drained
    task automatic test_drain_pause();
        send_event(dual_key(), 1'b1, 1'b0);
        send_event(plain_key(), 1'b1, 1'b0);
        wait_drained();
        send_event(plain_key(), 1'b0, 1'b0);
        send_event(window_base, 1'b0, 1'b0);
    endtask

    task automatic program_random_window();
        logic [31:0] e [4];
        logic [15:0] base;
        case ($urandom_range(0, 4))
            0: base = 16'h0000;
            1: base = 16'hFFFC + 16'($urandom_range(0, 3));
            default: base = 16'($urandom);
        endcase
        for (int i = 0; i < 4; i++) begin
            e[i] = $urandom;
            case ($urandom_range(0, 9))
                0, 1: e[i][15:0] = 16'd0;
                2, 3: e[i][15:0] = e[$urandom_range(0, 3)][15:0];
                4:    e[i] = 32'hFFFF_FFFF;
                default: ;
            endcase
        end
        program_window(base, e[0], e[1], e[2], e[3]);
    endtask

    // one hold of a dual-role key with random events in between
    task automatic play_hold();
        logic [15:0] held;
        logic [15:0] k;
        held = dual_key();
        send_event(held, 1'b1, 1'b0);
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 5))
                0: send_event(plain_key(), 1'b1, 1'($urandom));
                1: send_event(plain_key(), 1'b0, 1'($urandom));
                2: send_event(dual_key(), 1'b1, 1'b0);
                3: send_event(dual_key(), 1'b0, 1'b0);
                4: send_event(held, 1'b1, 1'b0);
                default: begin
                    k = dual_key();
                    send_event(k, 1'($urandom), 1'b1);
                end
            endcase
        end
        send_event(held, 1'b0, 1'b0);
    endtask

    // random phases, each under its own configuration
    task automatic test_random_holds(input int count);
        int target;
        target = events_sent + count;
        for (int phase = 0; phase < 4; phase++) begin
            program_random_window();
            sender_idles = (phase != 2);
            sink_idles = (phase != 2);
            while (events_sent < target - (3 - phase) * count / 4) begin
                case ($urandom_range(0, 9))
                    0: send_event(16'($urandom), 1'($urandom), 1'($urandom));
                    1: send_event(dual_key(), 1'b0, 1'b0);
                    default: play_hold();
                endcase
            end
        end
        sender_idles = 1'b1;
        sink_idles = 1'b1;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_WINDOW_BASE;
        cfg_wdata = '0;
        window_base = '0;
        foreach (entry_regs[i]) entry_regs[i] = '0;
        hold_valid = 1'b0;
        hold_slot = '0;
        hold_interrupted = 1'b0;
        overlap_tap = '0;
        sender_idles = 1'b1;
        sink_idles = 1'b1;
        events_sent = 0;
        beats_checked = 0;
        mismatches = 0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_directed_cases();
        test_window_edges();
        test_drain_pause();
        test_random_holds(176);

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("covered %0d key events and %0d result beats over several window settings",
                 events_sent, beats_checked);
        $display("taps, interrupts, overlaps, handled pass-through and window edges included");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
